[design/slot_occupancy_fit_finder_assert.svh]
// ---------------------------------------------------------------------------
// slot occupancy fit finder assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef SLOT_OCCUPANCY_FIT_FINDER_ASSERT_SVH
`define SLOT_OCCUPANCY_FIT_FINDER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SOFIT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SOFIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SOFIT_ASSERT_IMPL(lbl, ante, cons)
`define SOFIT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[design/sofit_pkg.sv]
// ---------------------------------------------------------------------------
// sofit_pkg
// shared types, sizes and helpers of the slot occupancy fit finder
// ---------------------------------------------------------------------------
package sofit_pkg;

  localparam int MAP_SLOTS = 64;
  localparam int SLOT_W    = 6;   // slot index width
  localparam int CNT_W     = 7;   // slot count width, holds MAP_SLOTS itself

  localparam logic [CNT_W-1:0] MAX_CAP = CNT_W'(MAP_SLOTS);

  // front to back queue
  localparam int QUEUE_DEPTH = 2;  // power of two
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CAPACITY = 2'd1,
    ST_OVERLAP  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } bk_state_t;

  // classified request as held in the queue
  typedef struct packed {
    op_t               op;
    logic              bad_cap;     // add run runs past the capacity
    logic              empty;       // query can never fit
    logic [SLOT_W-1:0] offset;
    logic [CNT_W-1:0]  width;
    logic [SLOT_W-1:0] last_start;  // last start offset a query scans
  } qentry_t;

  // width ones in the low bits, width up to MAP_SLOTS
  function automatic logic [MAP_SLOTS-1:0] slot_ones(input logic [CNT_W-1:0] width);
    logic [MAP_SLOTS-1:0] ones;
    if (width >= MAX_CAP) begin
      ones = '1;
    end else begin
      ones = (MAP_SLOTS'(1) << width[SLOT_W-1:0]) - MAP_SLOTS'(1);
    end
    return ones;
  endfunction

endpackage

[design/sofit_front.sv]
// ---------------------------------------------------------------------------
// sofit_front
// capacity register, request intake and classification into the queue
// ---------------------------------------------------------------------------
module sofit_front import sofit_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_capacity,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [SLOT_W-1:0] in_first_slot,
  input  logic [CNT_W-1:0]  in_run_len,
  input  logic              q_full,
  output logic              q_push,
  output qentry_t           q_push_data
);

  logic [CNT_W-1:0] cap_cfg_r;
  logic [CNT_W-1:0] cap;
  logic [CNT_W:0]   run_end;
  logic             known;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r <= MAX_CAP;
    end else if (cfg_valid) begin
      cap_cfg_r <= cfg_capacity;
    end
  end

  // saturate to the slot count of the map
  assign cap     = (cap_cfg_r > MAX_CAP) ? MAX_CAP : cap_cfg_r;
  assign run_end = {2'b00, in_first_slot} + {1'b0, in_run_len};

  always_comb begin
    known = 1'b1;
    case (op_t'(in_req_type))
      OP_CLEAR: q_push_data.op = OP_CLEAR;
      OP_ADD:   q_push_data.op = OP_ADD;
      OP_QUERY: q_push_data.op = OP_QUERY;
      default: begin
        q_push_data.op = OP_CLEAR;
        known          = 1'b0;   // unused code, dropped
      end
    endcase
    q_push_data.bad_cap    = run_end > {1'b0, cap};
    q_push_data.empty      = (in_run_len == '0) || (in_run_len > cap);
    q_push_data.offset     = in_first_slot;
    q_push_data.width      = in_run_len;
    q_push_data.last_start = SLOT_W'(cap - in_run_len);
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && known;

endmodule

[design/sofit_queue.sv]
// ---------------------------------------------------------------------------
// sofit_queue
// short fifo of classified requests between front and back
// ---------------------------------------------------------------------------
module sofit_queue import sofit_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  output logic    full,
  output logic    q_valid,
  output qentry_t q_data,
  input  logic    pop
);

  localparam logic [QPTR_W:0] DEPTH = (QPTR_W + 1)'(QUEUE_DEPTH);

  qentry_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign full    = (count_r == DEPTH);
  assign q_valid = (count_r != '0);
  assign q_data  = entry_r[rd_ptr_r];

`include "slot_occupancy_fit_finder_assert.svh"

  `SOFIT_ASSERT_IMPL(a_no_overflow, push && !pop, count_r != DEPTH)
  `SOFIT_ASSERT_NEXT(a_push_lands, push && !pop, count_r != '0)

endmodule

[design/sofit_back.sv]
// ---------------------------------------------------------------------------
// sofit_back
// occupancy map, add checks, query scan and output register
// ---------------------------------------------------------------------------
module sofit_back import sofit_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  qentry_t           q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic              out_offset_found,
  output logic [SLOT_W-1:0] out_fit_offset,
  output logic              out_last
);

  bk_state_t            state_r, state_nxt;
  logic [MAP_SLOTS-1:0] map_r, map_nxt;
  logic [MAP_SLOTS-1:0] shmap_r, shmap_nxt;
  logic [MAP_SLOTS-1:0] ones_r, ones_nxt;
  logic [SLOT_W-1:0]    s_r, s_nxt;
  logic [SLOT_W-1:0]    lastst_r, lastst_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]    pend_off_r, pend_off_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [SLOT_W-1:0]    out_off_r, out_off_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 out_free;
  logic                 hit;
  logic [MAP_SLOTS-1:0] add_mask;

  assign out_free = !out_valid_r || out_ready;
  assign hit      = (shmap_r & ones_r) == '0;
  assign add_mask = slot_ones(q_data.width) << q_data.offset;

  always_comb begin
    state_nxt      = state_r;
    map_nxt        = map_r;
    shmap_nxt      = shmap_r;
    ones_nxt       = ones_r;
    s_nxt          = s_r;
    lastst_nxt     = lastst_r;
    pend_v_nxt     = pend_v_r;
    pend_off_nxt   = pend_off_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_off_nxt    = out_off_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_data.op)
            OP_CLEAR: begin
              map_nxt        = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_found_nxt  = 1'b0;
              out_off_nxt    = '0;
              out_last_nxt   = 1'b1;
            end
            OP_ADD: begin
              out_valid_nxt  = 1'b1;
              out_found_nxt  = 1'b0;
              out_off_nxt    = '0;
              out_last_nxt   = 1'b1;
              if (q_data.bad_cap) begin
                out_status_nxt = ST_CAPACITY;
              end else if ((map_r & add_mask) != '0) begin
                out_status_nxt = ST_OVERLAP;
              end else begin
                out_status_nxt = ST_OK;
                map_nxt        = map_r | add_mask;
              end
            end
            OP_QUERY: begin
              pend_v_nxt   = 1'b0;
              pend_off_nxt = '0;
              shmap_nxt    = map_r;
              ones_nxt     = slot_ones(q_data.width);
              s_nxt        = '0;
              lastst_nxt   = q_data.last_start;
              state_nxt    = q_data.empty ? BK_FINISH : BK_SCAN;
            end
            default: begin
              map_nxt = map_r;
            end
          endcase
        end
      end
      BK_SCAN: begin
        // a second hit pushes the held one out, so it needs the output free
        if (!(hit && pend_v_r) || out_free) begin
          if (hit) begin
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_found_nxt  = 1'b1;
              out_off_nxt    = pend_off_r;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_off_nxt = s_r;
          end
          shmap_nxt = shmap_r >> 1;
          s_nxt     = s_r + 1'b1;
          if (s_r == lastst_r) begin
            state_nxt = BK_FINISH;
          end
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_found_nxt  = pend_v_r;
          out_off_nxt    = pend_v_r ? pend_off_r : '0;
          out_last_nxt   = 1'b1;
          state_nxt      = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      map_r       <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_r       <= map_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shmap_r      <= shmap_nxt;
    ones_r       <= ones_nxt;
    s_r          <= s_nxt;
    lastst_r     <= lastst_nxt;
    pend_off_r   <= pend_off_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_off_r    <= out_off_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_offset_found = out_found_r;
  assign out_fit_offset   = out_off_r;
  assign out_last         = out_last_r;

`include "slot_occupancy_fit_finder_assert.svh"

  `SOFIT_ASSERT_IMPL(a_found_ok, out_valid_r && out_found_r, out_status_r == ST_OK)
  `SOFIT_ASSERT_IMPL(a_nofind_zero, out_valid_r && !out_found_r, out_off_r == '0)
  `SOFIT_ASSERT_IMPL(a_scan_range, state_r == BK_SCAN, s_r <= lastst_r)

endmodule

[design/slot_occupancy_fit_finder.sv]
// ---------------------------------------------------------------------------
// slot_occupancy_fit_finder
// occupancy bitmap of tributary slots with a search for free runs
// ---------------------------------------------------------------------------
// Keeps a 64-bit map of occupied slots. A clear item frees every slot, an add
// item marks in_first_slot .. in_first_slot+in_run_len-1 and reports ok, beyond
// capacity or overlap (the map is untouched on an error), and a query item
// returns every start offset, lowest first, where in_run_len free slots fit
// within the capacity, last set on the final one; a query that fits nowhere
// gives a single not-found result. Request code 3 is dropped with no result.
// Capacity comes from cfg_capacity (reset 64, above 64 reads as 64) and is
// to be written only while the block is idle. Clear and add are handled
// straight from the idle state, so they sustain one item a cycle while the
// output is not stalled. A query is taken from the queue, then the
// single-window scan over the shifted map checks one candidate start offset
// at a time from 0 up to capacity - in_run_len, then a closing step gives
// the final result (a query that cannot fit goes straight there); output
// stalls hold it. A two-entry queue lets intake carry on while a query scans.
// ---------------------------------------------------------------------------
module slot_occupancy_fit_finder import sofit_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // capacity register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_capacity,
  // request items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [SLOT_W-1:0] in_first_slot,
  input  logic [CNT_W-1:0]  in_run_len,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic              out_offset_found,
  output logic [SLOT_W-1:0] out_fit_offset,
  output logic              out_last
);

  // front to queue
  logic    q_full;
  logic    q_push;
  qentry_t q_push_data;

  // queue to back
  logic    q_valid;
  qentry_t q_data;
  logic    q_pop;

  // intake: capacity register, request decode, capacity checks
  sofit_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_capacity  (cfg_capacity),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_first_slot (in_first_slot),
    .in_run_len    (in_run_len),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  // decouples intake from the map and scan
  sofit_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop)
  );

  // map update, overlap check, query scan and registered results
  sofit_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_offset_found (out_offset_found),
    .out_fit_offset   (out_fit_offset),
    .out_last         (out_last)
  );

endmodule
